// ----- rtl/debounced_toggle_auto_off_unit_macros.svh -----
// Assertion macros shared by the debounced toggle auto-off design.
`ifndef DEBOUNCED_TOGGLE_AUTO_OFF_UNIT_MACROS_SVH
`define DEBOUNCED_TOGGLE_AUTO_OFF_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DTAO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DTAO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DTAO_ASSERT_SAME(label, ante, cons)
`define DTAO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/dtao_pkg.sv -----
// Package with constants and types of the debounced toggle auto-off unit.
package dtao_pkg;

    localparam int HISTORY_BITS_DEFAULT = 8;
    localparam logic [31:0] HIST_PATTERN = 32'hAAAA_AAAA;

    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd30000;
    localparam logic [TICK_W-1:0] WAKE_RESET = 16'd50;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAKE = 2'd1;

    typedef struct packed {
        logic press;
        logic lamp_next;
    } lane_status_t;

endpackage

// ----- rtl/dtao_sample_if.sv -----
// Channel interface carrying one sample transaction of both buttons.
interface dtao_sample_if;
    logic valid;
    logic ready;
    logic button_one_pressed;
    logic button_two_pressed;

    modport source (output valid, output button_one_pressed, output button_two_pressed,
                    input ready);
    modport sink (input valid, input button_one_pressed, input button_two_pressed,
                  output ready);
endinterface

// ----- rtl/dtao_result_if.sv -----
// Channel interface carrying one result transaction of lamp states and sleep flag.
interface dtao_result_if;
    logic valid;
    logic ready;
    logic output_one_on;
    logic output_two_on;
    logic sleep_request;

    modport source (output valid, output output_one_on, output output_two_on,
                    output sleep_request, input ready);
    modport sink (input valid, input output_one_on, input output_two_on,
                  input sleep_request, output ready);
endinterface

// ----- rtl/dtao_lane.sv -----
// One button lane: shift history, held latch and toggled lamp state.
`include "debounced_toggle_auto_off_unit_macros.svh"

module dtao_lane #(
    parameter int HIST_W = dtao_pkg::HISTORY_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  sample,
    input  logic                  force_off,
    output dtao_pkg::lane_status_t status
);

    localparam logic [HIST_W-1:0] HIST_INIT = HIST_W'(dtao_pkg::HIST_PATTERN);

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;
    logic              held_reg;
    logic              held_next;
    logic              lamp_reg;
    logic              full;
    logic              press;

    assign hist_next = {hist_reg[HIST_W-2:0], sample};
    assign full      = &hist_next;
    assign press     = full && !held_reg;

    always_comb
    begin
        held_next = held_reg | full;
        if (hist_next == '0)
        begin
            held_next = 1'b0;
        end
    end

    assign status.press     = press;
    assign status.lamp_next = force_off ? 1'b0 : (lamp_reg ^ press);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= HIST_INIT;
            held_reg <= 1'b0;
            lamp_reg <= 1'b0;
        end
        else if (accept)
        begin
            hist_reg <= hist_next;
            held_reg <= held_next;
            lamp_reg <= status.lamp_next;
        end
    end

    `DTAO_ASSERT_NEXT(a_forced_off, accept && force_off, !lamp_reg)
    `DTAO_ASSERT_NEXT(a_press_holds, accept && press, held_reg)

endmodule

// ----- rtl/dtao_merge.sv -----
// Merge stage: shared countdown, reload registers and expiry decision.
`include "debounced_toggle_auto_off_unit_macros.svh"

module dtao_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  dtao_pkg::lane_status_t              status_one,
    input  dtao_pkg::lane_status_t              status_two,
    input  logic                                cfg_we,
    input  logic [dtao_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtao_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                expire
);

    logic [dtao_pkg::TICK_W-1:0] timeout_reg;
    logic [dtao_pkg::TICK_W-1:0] wake_reg;
    logic [dtao_pkg::TICK_W-1:0] remaining_reg;
    logic [dtao_pkg::TICK_W-1:0] remaining_next;
    logic [dtao_pkg::TICK_W-1:0] loaded;
    logic                        any_press;

    assign any_press      = status_one.press || status_two.press;
    assign loaded         = any_press ? timeout_reg : remaining_reg;
    assign expire         = (loaded == '0);
    assign remaining_next = (expire ? wake_reg : loaded) - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= dtao_pkg::TIMEOUT_RESET;
            wake_reg    <= dtao_pkg::WAKE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtao_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                dtao_pkg::REG_WAKE:    wake_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            remaining_reg <= remaining_next;
        end
    end

    `DTAO_ASSERT_NEXT(a_wake_reload, accept && expire, remaining_reg == $past(wake_reg) - 16'd1)
    `DTAO_ASSERT_NEXT(a_press_reload, accept && any_press && !expire, remaining_reg == $past(timeout_reg) - 16'd1)

endmodule

// ----- rtl/debounced_toggle_auto_off_unit.sv -----
// Top level of the debounced two-button toggle with shared auto-off countdown.
// Usage:
// The samples channel takes one transaction per tick with a raw sample of each button.
// The results channel returns one transaction per sample: both lamp states after the
// tick and a sleep request flag when the shared countdown expired in that tick.
// A valid result appears in the cycle after a sample is accepted.
// Throughput is one transaction per cycle while results are taken; both lanes and the
// countdown settle in the accepting cycle; the result sits in a single output register.
// When the receiver stalls, the held result stays on the results channel and the
// samples channel stays ready only if that register is empty or being taken.
// The configuration port writes the press timeout (index 0) and the wake reload
// (index 1); other indexes are ignored.
// Reset loads each history with the alternating pattern, clears latches and lamps,
// sets the reload values to 30000 and 50 and the countdown to zero, so the first
// sample raises a sleep request.
module debounced_toggle_auto_off_unit #(
    parameter int HISTORY_BITS = dtao_pkg::HISTORY_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dtao_sample_if.sink                      samples,
    dtao_result_if.source                    results,
    input  logic                             cfg_we,
    input  logic [dtao_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dtao_pkg::CFG_DATA_W-1:0]  cfg_data
);

    dtao_pkg::lane_status_t status_one;
    dtao_pkg::lane_status_t status_two;
    logic                   accept;
    logic                   expire;
    logic                   valid_reg;
    logic                   one_reg;
    logic                   two_reg;
    logic                   sleep_reg;

    assign samples.ready = !valid_reg || results.ready;
    assign accept        = samples.valid && samples.ready;

    dtao_lane #(
        .HIST_W (HISTORY_BITS)
    ) u_lane_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (samples.button_one_pressed),
        .force_off (expire),
        .status    (status_one)
    );

    dtao_lane #(
        .HIST_W (HISTORY_BITS)
    ) u_lane_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (samples.button_two_pressed),
        .force_off (expire),
        .status    (status_two)
    );

    dtao_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .status_one (status_one),
        .status_two (status_two),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .expire     (expire)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            one_reg   <= status_one.lamp_next;
            two_reg   <= status_two.lamp_next;
            sleep_reg <= expire;
        end
    end

    assign results.valid         = valid_reg;
    assign results.output_one_on = one_reg;
    assign results.output_two_on = two_reg;
    assign results.sleep_request = sleep_reg;

endmodule

// ----- tb/tb.sv -----
// Testbench for the debounced two-button toggle with shared auto-off countdown.
`timescale 1ns / 100ps

module tb;

    localparam int HB = dtao_pkg::HISTORY_BITS_DEFAULT;
    localparam logic [HB-1:0] HIST_START = dtao_pkg::HIST_PATTERN[HB-1:0];
    localparam logic [dtao_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [dtao_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int PHASES = 8;
    localparam int PHASE_SAMPLES = 180;
    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic one_on;
        logic two_on;
        logic sleep;
    } lamp_result_t;

    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_CYCLIC, SINK_STARVED} sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [dtao_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dtao_pkg::CFG_DATA_W-1:0] cfg_data;

    dtao_sample_if sample_bus ();
    dtao_result_if result_bus ();

    debounced_toggle_auto_off_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_bus),
        .results   (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [dtao_pkg::TICK_W-1:0] timeout_reload = dtao_pkg::TIMEOUT_RESET;
    logic [dtao_pkg::TICK_W-1:0] wake_reload = dtao_pkg::WAKE_RESET;
    logic [dtao_pkg::TICK_W-1:0] countdown = '0;
    logic [HB-1:0] lane_history [2] = '{HIST_START, HIST_START};
    logic lane_held [2] = '{1'b0, 1'b0};
    logic lane_lamp [2] = '{1'b0, 1'b0};

    lamp_result_t pending_results [$];

    int unsigned errors = 0;
    int unsigned samples_taken = 0;
    int unsigned results_checked = 0;
    int unsigned sleeps_seen = 0;
    int unsigned toggles_on = 0;
    int unsigned reg_writes = 0;

    int unsigned burst_left = 0;
    bit gaps_on = 1'b1;
    bit stream_live = 1'b0;
    logic level [2] = '{1'b0, 1'b0};
    int unsigned run_left [2] = '{0, 0};

    sink_mode_t sink_mode = SINK_OPEN;
    int unsigned sink_span = 0;
    int unsigned sink_tick = 0;

    always #4 clk = ~clk;

    function automatic lamp_result_t advance_tick(input logic raw_one, input logic raw_two);
        logic raw [2];
        lamp_result_t r;
        raw[0] = raw_one;
        raw[1] = raw_two;
        for (int k = 0; k < 2; k++)
        begin
            lane_history[k] = {lane_history[k][HB-2:0], raw[k]};
            if (&lane_history[k] && !lane_held[k])
            begin
                lane_held[k] = 1'b1;
                lane_lamp[k] = !lane_lamp[k];
                countdown = timeout_reload;
            end
            if (lane_history[k] == '0)
            begin
                lane_held[k] = 1'b0;
            end
        end
        r.sleep = 1'b0;
        if (countdown == '0)
        begin
            lane_lamp[0] = 1'b0;
            lane_lamp[1] = 1'b0;
            r.sleep = 1'b1;
            countdown = wake_reload;
        end
        countdown = countdown - 16'd1;
        r.one_on = lane_lamp[0];
        r.two_on = lane_lamp[1];
        return r;
    endfunction

    task automatic check_bit(input string what, input logic want, input logic got);
        if (got !== want)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, what, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        lamp_result_t seen;
        lamp_result_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                seen = {result_bus.output_one_on, result_bus.output_two_on,
                        result_bus.sleep_request};
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result transaction, expected none, actual %b",
                                 $time, seen);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_bit("output_one_on", want.one_on, seen.one_on);
                    check_bit("output_two_on", want.two_on, seen.two_on);
                    check_bit("sleep_request", want.sleep, seen.sleep);
                    results_checked++;
                    if (want.sleep)
                    begin
                        sleeps_seen++;
                    end
                end
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                want = advance_tick(sample_bus.button_one_pressed,
                                    sample_bus.button_two_pressed);
                pending_results.push_back(want);
                samples_taken++;
                if (want.one_on || want.two_on)
                begin
                    toggles_on++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (sink_span == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_span = $urandom_range(20, 150);
        end
        sink_span--;
        sink_tick++;
        case (sink_mode)
            SINK_OPEN:    result_bus.ready <= 1'b1;
            SINK_RANDOM:  result_bus.ready <= ($urandom_range(0, 3) != 0);
            SINK_CYCLIC:  result_bus.ready <= ((sink_tick % 7) < 4);
            default:      result_bus.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_sample(input logic raw_one, input logic raw_two);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                if (stream_live)
                begin
                    sample_bus.valid <= 1'b0;
                    stream_live = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_bus.valid <= 1'b1;
        sample_bus.button_one_pressed <= raw_one;
        sample_bus.button_two_pressed <= raw_two;
        stream_live = 1'b1;
        @(posedge clk);
        while (!sample_bus.ready) @(posedge clk);
    endtask

    task automatic pause_stream();
        if (stream_live)
        begin
            sample_bus.valid <= 1'b0;
            stream_live = 1'b0;
        end
        do @(posedge clk); while (pending_results.size() != 0);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [dtao_pkg::CFG_INDEX_W-1:0] index,
                             input logic [dtao_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            dtao_pkg::REG_TIMEOUT: timeout_reload = value;
            dtao_pkg::REG_WAKE:    wake_reload = value;
            default:               ;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_power_up();
        send_sample(1'b0, 1'b0);
        pause_stream();
    endtask

    task automatic test_zero_reloads();
        write_reg(dtao_pkg::REG_TIMEOUT, 16'd0);
        write_reg(dtao_pkg::REG_WAKE, 16'd0);
        repeat (HB) send_sample(1'b1, 1'b0);
        pause_stream();
    endtask

    task automatic test_press_then_expire();
        write_reg(dtao_pkg::REG_TIMEOUT, 16'd3);
        write_reg(dtao_pkg::REG_WAKE, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        repeat (HB) send_sample(1'b0, 1'b1);
        repeat (4) send_sample(1'b0, 1'b0);
        pause_stream();
    endtask

    task automatic run_bouncy_stream(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (run_left[k] == 0)
                begin
                    level[k] = !level[k];
                    run_left[k] = ($urandom_range(0, 9) < 7) ? $urandom_range(HB, 30)
                                                             : $urandom_range(1, 5);
                end
                run_left[k]--;
            end
            if ($urandom_range(0, 19) == 0)
            begin
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_sample(level[0], level[1]);
            end
            if ($urandom_range(0, 149) == 0)
            begin
                pause_stream();
            end
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            pause_stream();
            case (p)
                0:
                begin
                    write_reg(dtao_pkg::REG_TIMEOUT, 16'd20);
                    write_reg(dtao_pkg::REG_WAKE, 16'd5);
                end
                1:
                begin
                    write_reg(dtao_pkg::REG_TIMEOUT, 16'hFFFF);
                    write_reg(dtao_pkg::REG_WAKE, 16'd1);
                end
                2:
                begin
                    write_reg(dtao_pkg::REG_TIMEOUT, 16'd1);
                    write_reg(dtao_pkg::REG_WAKE, 16'hFFFF);
                end
                3:
                begin
                    write_reg(dtao_pkg::REG_TIMEOUT, 16'd0);
                    write_reg(dtao_pkg::REG_WAKE, 16'd0);
                end
                default:
                begin
                    write_reg(dtao_pkg::REG_TIMEOUT, 16'($urandom_range(1, 80)));
                    write_reg(dtao_pkg::REG_WAKE, 16'($urandom_range(1, 30)));
                    write_reg(REG_SPARE_LO, 16'($urandom_range(0, 16'hFFFF)));
                    write_reg(REG_SPARE_HI, 16'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            gaps_on = (p % 3 != 1);
            run_bouncy_stream(PHASE_SAMPLES);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = dtao_pkg::REG_TIMEOUT;
        cfg_data = '0;
        sample_bus.valid = 1'b0;
        sample_bus.button_one_pressed = 1'b0;
        sample_bus.button_two_pressed = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_zero_reloads();
        test_press_then_expire();
        test_random_phases();

        pause_stream();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Covered %0d sample transactions and %0d checked results, %0d with sleep.",
                 samples_taken, results_checked, sleeps_seen);
        $display("Lamps were on in %0d results; %0d register writes across %0d phases.",
                 toggles_on, reg_writes, PHASES);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run timed out at %0t.", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
